FILE: design/kdt_pkg.sv
// Package for the keyed dense table: sizes, command and status codes, and the
// request, result, entry and memory port types. Used by every file of the block.
// No dependencies.
package kdt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [2:0] CMD_ADD        = 3'd0;
  localparam logic [2:0] CMD_DEL_SWAP   = 3'd1;
  localparam logic [2:0] CMD_DEL_ORD    = 3'd2;
  localparam logic [2:0] CMD_FIND       = 3'd3;
  localparam logic [2:0] CMD_UPDATE     = 3'd4;
  localparam logic [2:0] CMD_READ_SLOT  = 3'd5;
  localparam logic [2:0] CMD_CLEAR_RARE = 3'd6;
  localparam logic [2:0] CMD_MARK_RARE  = 3'd7;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_DUP        = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_SLOT_RANGE = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] item_id;
    logic signed [31:0] quantity_in;
    logic [31:0]        price_cents_in;
    logic [5:0]         slot_in;
  } kdt_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_id;
    logic signed [31:0] entry_quantity;
    logic [31:0]        entry_price_cents;
    logic [5:0]         entry_slot;
    logic               entry_rare;
    logic [6:0]         entry_count;
  } kdt_rsp_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] qty;
    logic [31:0]        price;
  } kdt_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    kdt_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } kdt_mem_req_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] a);
    return SLOT_W'(a);
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    return COUNT_W'(c);
  endfunction

endpackage

FILE: design/keyed_dense_table_core.sv
// Keyed dense table: a packed table of up to CAPACITY entries searched by id.
// Requests enter on the in_ channel and each gives one result on the out_
// channel. Results pass through an output register, so the sequencer can take
// the next request while a result still waits to be taken.
// Every request is accepted only while the sequencer is idle; in_stall is high
// during the whole command. An id scan reads one stored entry per cycle through
// the single entry memory read port and the single id comparator, and it ends
// at the first hit or after the last entry. A find accepts the request, then
// scans, executes and hands off its result, in that order. An ordered delete
// then moves the later entries one per cycle through the same memory port; a
// swap delete moves the last entry into the freed slot. Read slot reads the
// entry memory once, and clear rare or a read beyond the count go straight to
// the result. Reset empties the table and clears all rare flags at once; entry
// contents are left as they are and are never read before being written.
// If the receiver holds out_stall, the result stays in the output register,
// one more request can be executed, and its result waits in the sequencer,
// which then stalls the input until the output register frees up.
// Depends on kdt_pkg, kdt_store and kdt_ctrl.
module keyed_dense_table_core
  import kdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kdt_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kdt_rsp_t out_data
);

  kdt_mem_req_t mreq;
  kdt_entry_t   rd_data;
  logic         res_valid;
  logic         res_ack;
  kdt_rsp_t     res;
  logic         out_valid_r;
  kdt_rsp_t     out_data_r;

  kdt_store u_store (
    .clk       (clk),
    .mreq      (mreq),
    .rd_data_r (rd_data)
  );

  kdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mreq      (mreq),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res)
  );

  assign res_ack = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/kdt_store.sv
// Entry memory of the keyed dense table: id, quantity and price per slot.
// One write port and one registered read port. Depends on kdt_pkg.
module kdt_store
  import kdt_pkg::*;
(
  input  logic         clk,
  input  kdt_mem_req_t mreq,
  output kdt_entry_t   rd_data_r
);

  kdt_entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rd_data_r <= mem[mreq.raddr];
  end

endmodule

FILE: design/kdt_ctrl.sv
// Command sequencer of the keyed dense table: id scan through the single id
// comparator, entry moves for deletes, rare flags and entry count.
// Depends on kdt_pkg and drives the port of kdt_store.
module kdt_ctrl
  import kdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  kdt_req_t     in_data,
  output kdt_mem_req_t mreq,
  input  kdt_entry_t   rd_data,
  output logic         res_valid,
  input  logic         res_ack,
  output kdt_rsp_t     res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAPACITY-1:0] rare_r, rare_nxt;
  logic                pend_r, pend_nxt;
  logic                wpend_r, wpend_nxt;
  kdt_req_t            req_r, req_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [IDX_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_addr_r, hit_addr_nxt;
  kdt_entry_t          ent_r, ent_nxt;
  logic [CNT_W-1:0]    src_r, src_nxt;
  logic                swap_r, swap_nxt;
  logic [IDX_W-1:0]    wdst_r, wdst_nxt;
  logic [IDX_W-1:0]    wsrc_r, wsrc_nxt;
  kdt_rsp_t            res_r, res_nxt;
  logic [CNT_W-1:0]    last;
  logic                match;
  logic                hit_rare;

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign last      = count_r - CNT_W'(1);
  assign match     = pend_r && (rd_data.id == req_r.item_id);
  assign hit_rare  = rare_r[hit_addr_r];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rare_nxt      = rare_r;
    pend_nxt      = pend_r;
    wpend_nxt     = wpend_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    pend_addr_nxt = pend_addr_r;
    hit_nxt       = hit_r;
    hit_addr_nxt  = hit_addr_r;
    ent_nxt       = ent_r;
    src_nxt       = src_r;
    swap_nxt      = swap_r;
    wdst_nxt      = wdst_r;
    wsrc_nxt      = wsrc_r;
    res_nxt       = res_r;
    mreq          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt             = in_data;
          res_nxt             = '0;
          res_nxt.status      = ST_OK;
          res_nxt.entry_count = to_count(count_r);
          case (in_data.cmd)
            CMD_CLEAR_RARE: begin
              rare_nxt  = '0;
              state_nxt = S_DONE;
            end
            CMD_READ_SLOT: begin
              if (32'(in_data.slot_in) >= 32'(count_r)) begin
                res_nxt.status = ST_SLOT_RANGE;
                state_nxt      = S_DONE;
              end else begin
                mreq.raddr = IDX_W'(in_data.slot_in);
                state_nxt  = S_READ;
              end
            end
            default: begin
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.entry_id          = rd_data.id;
        res_nxt.entry_quantity    = rd_data.qty;
        res_nxt.entry_price_cents = rd_data.price;
        res_nxt.entry_slot        = req_r.slot_in;
        res_nxt.entry_rare        = rare_r[IDX_W'(req_r.slot_in)];
        state_nxt                 = S_DONE;
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt      = 1'b1;
          hit_addr_nxt = pend_addr_r;
          ent_nxt      = rd_data;
          pend_nxt     = 1'b0;
          state_nxt    = S_EXEC;
        end else if (scan_r == count_r) begin
          hit_nxt   = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end else begin
          mreq.raddr    = scan_r[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_r[IDX_W-1:0];
          scan_nxt      = scan_r + CNT_W'(1);
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (!hit_r) begin
          if (req_r.cmd == CMD_ADD) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_nxt.status = ST_FULL;
            end else begin
              mreq.we                         = 1'b1;
              mreq.waddr                      = count_r[IDX_W-1:0];
              mreq.wdata.id                   = req_r.item_id;
              mreq.wdata.qty                  = req_r.quantity_in;
              mreq.wdata.price                = req_r.price_cents_in;
              rare_nxt[count_r[IDX_W-1:0]]    = 1'b0;
              count_nxt                       = count_r + CNT_W'(1);
              res_nxt.entry_id                = req_r.item_id;
              res_nxt.entry_quantity          = req_r.quantity_in;
              res_nxt.entry_price_cents       = req_r.price_cents_in;
              res_nxt.entry_slot              = to_slot(count_r[IDX_W-1:0]);
              res_nxt.entry_rare              = 1'b0;
              res_nxt.entry_count             = to_count(count_r + CNT_W'(1));
            end
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end else begin
          res_nxt.entry_id          = ent_r.id;
          res_nxt.entry_quantity    = ent_r.qty;
          res_nxt.entry_price_cents = ent_r.price;
          res_nxt.entry_slot        = to_slot(hit_addr_r);
          res_nxt.entry_rare        = hit_rare;
          case (req_r.cmd)
            CMD_ADD: begin
              res_nxt.status = ST_DUP;
            end
            CMD_DEL_SWAP: begin
              src_nxt             = last;
              swap_nxt            = 1'b1;
              wpend_nxt           = 1'b0;
              res_nxt.entry_count = to_count(last);
              state_nxt           = S_SHIFT;
            end
            CMD_DEL_ORD: begin
              src_nxt             = CNT_W'(hit_addr_r) + CNT_W'(1);
              swap_nxt            = 1'b0;
              wpend_nxt           = 1'b0;
              res_nxt.entry_count = to_count(last);
              state_nxt           = S_SHIFT;
            end
            CMD_UPDATE: begin
              mreq.we                = 1'b1;
              mreq.waddr             = hit_addr_r;
              mreq.wdata.id          = ent_r.id;
              mreq.wdata.qty         = req_r.quantity_in;
              mreq.wdata.price       = ent_r.price;
              res_nxt.entry_quantity = req_r.quantity_in;
              if (req_r.quantity_in == 32'sd0) begin
                rare_nxt[hit_addr_r] = 1'b0;
                res_nxt.entry_rare   = 1'b0;
              end
            end
            CMD_MARK_RARE: begin
              if (ent_r.qty != 32'sd0) begin
                rare_nxt[hit_addr_r] = 1'b1;
                res_nxt.entry_rare   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (wpend_r) begin
          mreq.we          = 1'b1;
          mreq.waddr       = wdst_r;
          mreq.wdata       = rd_data;
          rare_nxt[wdst_r] = rare_r[wsrc_r];
        end
        if (src_r < count_r) begin
          mreq.raddr = src_r[IDX_W-1:0];
          wpend_nxt  = 1'b1;
          wsrc_nxt   = src_r[IDX_W-1:0];
          wdst_nxt   = swap_r ? hit_addr_r : (src_r[IDX_W-1:0] - IDX_W'(1));
          src_nxt    = swap_r ? count_r : (src_r + CNT_W'(1));
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            rare_nxt[last[IDX_W-1:0]] = 1'b0;
            count_nxt                 = last;
            state_nxt                 = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rare_r  <= '0;
      pend_r  <= 1'b0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rare_r  <= rare_nxt;
      pend_r  <= pend_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    hit_r       <= hit_nxt;
    hit_addr_r  <= hit_addr_nxt;
    ent_r       <= ent_nxt;
    src_r       <= src_nxt;
    swap_r      <= swap_nxt;
    wdst_r      <= wdst_nxt;
    wsrc_r      <= wsrc_nxt;
    res_r       <= res_nxt;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= count_r))
    else $error("Id scan ran past the last entry.");

  a_rare_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (rare_r >> count_r) == '0)
    else $error("A rare flag is set on an unused slot.");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> (state_r == S_EXEC || state_r == S_SHIFT))
    else $error("Entry memory written outside execute or move.");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("Accepted request did not start the sequencer.");

endmodule
